/* rtl/core/lz78_pkg.sv */
// ----------------------------------------------------------------------------
// lz78_pkg
// Shared constants, types and helpers for the lz78 encoder.
// ----------------------------------------------------------------------------
package lz78_pkg;

    localparam int DICT_SIZE = 1024;
    localparam int SYM_W     = 8;
    localparam int IDX_W     = 11;
    localparam int ADDR_W    = (DICT_SIZE > 1) ? $clog2(DICT_SIZE) : 1;
    localparam int CNT_W     = $clog2(DICT_SIZE + 1);

    // one dictionary entry: prefix index and the byte that extends it
    typedef struct packed {
        logic [CNT_W-1:0] prefix;
        logic [SYM_W-1:0] symbol;
    } lz78_entry_t;

    // one result item
    typedef struct packed {
        logic [IDX_W-1:0] prefix_index;
        logic [SYM_W-1:0] out_symbol;
        logic [IDX_W-1:0] new_entry;
    } lz78_res_t;

    // index reported on the output, zero-extended or masked to IDX_W bits
    function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] v);
        logic [CNT_W+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, v};
        return wide[IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/lz78_dict.sv */
// ----------------------------------------------------------------------------
// lz78_dict
// Dictionary store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lz78_dict (
    input  logic                  clk,
    input  logic                  we,
    input  logic [lz78_pkg::ADDR_W-1:0] waddr,
    input  lz78_pkg::lz78_entry_t wdata,
    input  logic                  re,
    input  logic [lz78_pkg::ADDR_W-1:0] raddr,
    output lz78_pkg::lz78_entry_t rdata
);
    import lz78_pkg::*;

    lz78_entry_t mem [DICT_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/lz78_seq.sv */
// ----------------------------------------------------------------------------
// lz78_seq
// Sequencer: linear dictionary search with one shared entry compare,
// then emit on a miss and append while the dictionary has room.
// ----------------------------------------------------------------------------
module lz78_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lz78_pkg::SYM_W-1:0]  symbol,
    input  logic                        start_of_message,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lz78_pkg::lz78_res_t         res,
    output logic                        rd_en,
    output logic [lz78_pkg::ADDR_W-1:0] rd_addr,
    input  lz78_pkg::lz78_entry_t       rd_data,
    output logic                        wr_en,
    output logic [lz78_pkg::ADDR_W-1:0] wr_addr,
    output lz78_pkg::lz78_entry_t       wr_data
);
    import lz78_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] prefix_reg, prefix_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             cmp_pend_reg, cmp_pend_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic hit;
    logic full;

    assign hit  = cmp_pend_reg && (rd_data.prefix == prefix_reg)
                  && (rd_data.symbol == sym_reg);
    assign full = (count_reg == CNT_W'(DICT_SIZE));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        prefix_next   = prefix_reg;
        sym_next      = sym_reg;
        issue_next    = issue_reg;
        cmp_pend_next = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        rd_en         = 1'b0;
        rd_addr       = issue_reg[ADDR_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data.prefix = prefix_reg;
        wr_data.symbol = sym_reg;
        res_valid     = 1'b0;
        res.prefix_index = to_idx(prefix_reg);
        res.out_symbol   = sym_reg;
        res.new_entry    = full ? '0 : to_idx(CNT_W'(count_reg + 1'b1));

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next   = symbol;
                    issue_next = '0;
                    if (start_of_message)
                    begin
                        count_next  = '0;
                        prefix_next = '0;
                    end
                    // empty dictionary misses at once
                    if (start_of_message || count_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    prefix_next = cmp_idx_reg;
                    state_next  = ST_IDLE;
                end
                else if (issue_reg < count_reg)
                begin
                    // read entry issue_reg, compared in the next cycle
                    rd_en         = 1'b1;
                    issue_next    = CNT_W'(issue_reg + 1'b1);
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = CNT_W'(issue_reg + 1'b1);
                end
                else if (!cmp_pend_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    prefix_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            prefix_reg   <= '0;
            cmp_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prefix_reg   <= prefix_next;
            cmp_pend_reg <= cmp_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
    end

endmodule

/* rtl/core/lz78_encoder.sv */
// ----------------------------------------------------------------------------
// lz78_encoder
// LZ78 encoder, one byte per input item, zero or one code per byte.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with symbol and start_of_message. A byte
// flagged start_of_message empties the dictionary and prefix before it is
// encoded. Output channel: out_valid/out_ready with prefix_index, out_symbol
// and new_entry (0 when the dictionary is full).
// Each byte is searched linearly over the stored entries with one compare
// per cycle against a dictionary memory with registered read. A miss
// compares all stored entries before its code is emitted; a hit stops the
// search at the matching entry and frees the input. An empty dictionary or
// a start of message skips the search and goes straight to emit. A hit
// gives no output item. in_ready is high only while the sequencer is idle,
// so the next byte is taken only once the current one is done; the code
// passes from the emit state into an output register.
// A stalled receiver holds the output register; the next miss waits for it
// to drain, while searches for later bytes still proceed.
// Reset clears the dictionary count and prefix; no clearing pass is needed
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module lz78_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [lz78_pkg::SYM_W-1:0] symbol,
    input  logic                       start_of_message,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lz78_pkg::IDX_W-1:0] prefix_index,
    output logic [lz78_pkg::SYM_W-1:0] out_symbol,
    output logic [lz78_pkg::IDX_W-1:0] new_entry
);
    import lz78_pkg::*;

    logic              res_valid;
    logic              res_ready;
    lz78_res_t         res;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    lz78_entry_t       rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    lz78_entry_t       wr_data;

    logic      out_valid_reg, out_valid_next;
    lz78_res_t out_reg, out_next;

    lz78_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .symbol           (symbol),
        .start_of_message (start_of_message),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    lz78_dict u_dict (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // output register takes a new code once the previous one is gone
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign prefix_index = out_reg.prefix_index;
    assign out_symbol   = out_reg.out_symbol;
    assign new_entry    = out_reg.new_entry;

endmodule

/* tb/sv/lz78_encoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_encoder_checker
// Watches both channels of the lz78 encoder. Keeps its own copy of the
// dictionary and the matched prefix, predicts the code, if any, for every
// accepted byte, and compares each emitted code field by field in order.
// ----------------------------------------------------------------------------
module lz78_encoder_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [lz78_pkg::SYM_W-1:0] symbol,
    input  logic                       start_of_message,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [lz78_pkg::IDX_W-1:0] prefix_index,
    input  logic [lz78_pkg::SYM_W-1:0] out_symbol,
    input  logic [lz78_pkg::IDX_W-1:0] new_entry,
    output int                         errors,
    output int                         pending,
    output int                         codes_seen,
    output int                         full_codes
);

    import lz78_pkg::*;

    logic [IDX_W-1:0] dict_prefix [DICT_SIZE];
    logic [SYM_W-1:0] dict_symbol [DICT_SIZE];
    int               dict_count;
    logic [IDX_W-1:0] match_prefix;
    lz78_res_t        code_queue [$];
    int               reports;

    task automatic encode_byte(input logic [SYM_W-1:0] b, input logic som);
        int        hit;
        lz78_res_t code;
        hit = 0;
        if (som)
        begin
            dict_count   = 0;
            match_prefix = '0;
        end
        for (int k = 0; k < dict_count; k++)
        begin
            if (dict_prefix[k] == match_prefix && dict_symbol[k] == b)
            begin
                hit = k + 1;
                break;
            end
        end
        if (hit != 0)
        begin
            match_prefix = IDX_W'(hit);
        end
        else
        begin
            code.prefix_index = match_prefix;
            code.out_symbol   = b;
            code.new_entry    = '0;
            if (dict_count < DICT_SIZE)
            begin
                dict_prefix[dict_count] = match_prefix;
                dict_symbol[dict_count] = b;
                dict_count++;
                code.new_entry = IDX_W'(dict_count);
            end
            else
            begin
                full_codes++;
            end
            code_queue = {code_queue, code};
            match_prefix = '0;
        end
    endtask

    task automatic check_code(input lz78_res_t got);
        lz78_res_t want;
        if (code_queue.size() == 0)
        begin
            errors++;
            if (reports < 10)
            begin
                reports++;
                $display("%t: code with nothing expected: prefix %0d symbol %02h entry %0d",
                         $time, got.prefix_index, got.out_symbol, got.new_entry);
            end
        end
        else
        begin
            want = code_queue.pop_front();
            codes_seen++;
            if (got.prefix_index !== want.prefix_index || got.out_symbol !== want.out_symbol
                || got.new_entry !== want.new_entry)
            begin
                errors++;
                if (reports < 10)
                begin
                    reports++;
                    $display("%t: code mismatch: expected prefix %0d symbol %02h entry %0d,",
                             $time, want.prefix_index, want.out_symbol, want.new_entry);
                    $display("    got prefix %0d symbol %02h entry %0d",
                             got.prefix_index, got.out_symbol, got.new_entry);
                end
            end
        end
    endtask

    // output side first: a code seen at this edge can only come from an earlier byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dict_count   = 0;
            match_prefix = '0;
            code_queue.delete();
            errors       = 0;
            pending      = 0;
            codes_seen   = 0;
            full_codes   = 0;
            reports      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_code('{prefix_index, out_symbol, new_entry});
            if (in_valid && in_ready)
                encode_byte(symbol, start_of_message);
            pending = code_queue.size();
        end
    end

endmodule

/* tb/sv/lz78_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_encoder_tb
// Drives bytes into the lz78 encoder under random sender bursts and receiver
// stalls: a short directed opening, one long message that grows a large
// dictionary, then random messages over small and full alphabets.
// The checker beside the block predicts and compares the codes.
// ----------------------------------------------------------------------------
module lz78_encoder_tb;

    import lz78_pkg::*;

    localparam int IDLE_LIMIT = 8 * (DICT_SIZE + 64);

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [SYM_W-1:0] symbol;
    logic             start_of_message;
    logic             out_valid;
    logic             out_ready;
    logic [IDX_W-1:0] prefix_index;
    logic [SYM_W-1:0] out_symbol;
    logic [IDX_W-1:0] new_entry;

    int errors;
    int pending;
    int codes_seen;
    int full_codes;
    int bytes_sent;
    int long_bytes;
    int burst_left;
    int idle_cycles;

    lz78_encoder DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .symbol           (symbol),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .prefix_index     (prefix_index),
        .out_symbol       (out_symbol),
        .new_entry        (new_entry)
    );

    lz78_encoder_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .symbol           (symbol),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .prefix_index     (prefix_index),
        .out_symbol       (out_symbol),
        .new_entry        (new_entry),
        .errors           (errors),
        .pending          (pending),
        .codes_seen       (codes_seen),
        .full_codes       (full_codes)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender gaps come only between bursts
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic put_byte(input logic [SYM_W-1:0] b, input logic som);
        pace();
        in_valid         <= 1'b1;
        symbol           <= b;
        start_of_message <= som;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // hold the sender until every predicted code has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // one long message that leaves several hundred entries to search
    task automatic grow_dictionary();
        logic [SYM_W-1:0] perm [256];
        logic [SYM_W-1:0] t;
        int               j;
        for (int i = 0; i < 256; i++)
            perm[i] = SYM_W'(i);
        for (int i = 255; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        // every single byte first: entries 1..256
        for (int i = 0; i < 256; i++)
            put_byte(perm[i], i == 0);
        // each pair: a hit on a single byte, then a miss that adds (entry, byte);
        // first bytes are all different so pairs never repeat
        for (int k = 0; k < 64; k++)
        begin
            put_byte(perm[k], 1'b0);
            put_byte(SYM_W'($urandom_range(0, 255)), 1'b0);
        end
        for (int i = 0; i < 20; i++)
            put_byte(SYM_W'($urandom_range(0, 255)), 1'b0);
        long_bytes = bytes_sent;
    endtask

    task automatic random_messages(input int count);
        int               len;
        int               alpha;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] b;
        bit               noise;
        int               done;
        done = 0;
        while (done < count)
        begin
            len   = $urandom_range(1, 40);
            alpha = $urandom_range(0, 4);
            base  = SYM_W'($urandom_range(0, 255));
            noise = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++)
            begin
                if (noise || alpha == 0)
                    b = SYM_W'($urandom_range(0, 255));
                else
                    b = base + SYM_W'($urandom_range(0, alpha - 1));
                if (noise)
                    put_byte(b, $urandom_range(0, 9) == 0);
                else
                    put_byte(b, i == 0 && $urandom_range(0, 9) != 0);
                done++;
            end
            if ($urandom_range(0, 14) == 0)
                drain();
        end
    endtask

    // receiver: ready stretches, light and heavy stall patterns
    initial
    begin
        int mode;
        int len;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 120);
            repeat (len)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("lz78_encoder_tb: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        symbol           <= '0;
        start_of_message <= 1'b0;
        bytes_sent = 0;
        long_bytes = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no start flag yet: encode straight from reset
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        // start flag twice in a row, the second on a byte that would otherwise hit
        put_byte(8'hAA, 1'b1);
        put_byte(8'hAA, 1'b1);
        put_byte(8'hAA, 1'b0);
        // start flag in the middle of a match drops the prefix
        put_byte(8'h55, 1'b1);
        put_byte(8'h55, 1'b0);
        put_byte(8'h55, 1'b0);
        for (int i = 0; i < SYM_W; i++)
            put_byte(SYM_W'(1 << i), 1'b0);
        drain();

        grow_dictionary();
        drain();

        random_messages(140);

        drain();
        repeat (DICT_SIZE + 16) @(posedge clk);
        $display("covered %0d bytes (%0d up to the end of the long message)",
                 bytes_sent, long_bytes);
        $display("checked %0d codes, %0d of them with the dictionary full",
                 codes_seen, full_codes);
        if (errors == 0 && pending == 0)
            $display("lz78_encoder_tb: done, clean");
        else
            $display("lz78_encoder_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lz78_pkg.sv
rtl/core/lz78_dict.sv
rtl/core/lz78_seq.sv
rtl/core/lz78_encoder.sv
tb/sv/lz78_encoder_checker.sv
tb/sv/lz78_encoder_tb.sv
